/* rtl/nts_pkg.sv */
// nts_pkg: shared constants, request and status types for the nearest texture sampler
// no dependencies; imported by every rtl module of the sampler
`default_nettype none

package nts_pkg;

  // storage and coordinate format
  localparam int unsigned MAX_TEXELS      = 65536;
  localparam int unsigned COORD_FRAC_BITS = 16;
  localparam int unsigned TEX_AW          = $clog2(MAX_TEXELS);

  // fixed field widths
  localparam int unsigned DIM_W     = 17;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned COORD_W   = 32;
  localparam int unsigned TEXEL_W   = 32;
  localparam int unsigned LOAD_AW   = 16;
  localparam int unsigned IDX_W     = POS_W + DIM_W + 1;
  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEX_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TEX_HEIGHT = CFG_IDX_W'(1);

  localparam logic [TEXEL_W-1:0] OPAQUE_WHITE = {TEXEL_W{1'b1}};

  // queue between front and back, and result buffer
  localparam int unsigned Q_DEPTH  = 2;
  localparam int unsigned Q_AW     = $clog2(Q_DEPTH);
  localparam int unsigned OB_DEPTH = 4;
  localparam int unsigned OB_AW    = $clog2(OB_DEPTH);
  localparam int unsigned OB_CW    = $clog2(OB_DEPTH + 1);

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic               is_load;
    logic               dflt;
    logic [LOAD_AW-1:0] load_addr;
    logic [TEXEL_W-1:0] texel;
    logic [POS_W-1:0]   col;
    logic [POS_W-1:0]   row;
  } cmd_t;

  typedef struct packed {
    logic f1_valid;
    logic f2_valid;
  } fe_status_t;

  typedef struct packed {
    logic             a_valid;
    logic             mem_valid;
    logic [OB_CW-1:0] ob_count;
  } bk_status_t;

endpackage

`default_nettype wire

/* rtl/nts_front.sv */
// nts_front: accepts requests, flags default cases, wraps, scales and clamps coordinates
// depends on nts_pkg; feeds nts_queue
`default_nettype none

module nts_front import nts_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cfg_t                      cfg_i,
  input  logic                      push,
  output logic                      full,
  input  logic                      kind_i,
  input  logic        [LOAD_AW-1:0] load_address_i,
  input  logic        [TEXEL_W-1:0] load_texel_i,
  input  logic signed [COORD_W-1:0] coord_u_i,
  input  logic signed [COORD_W-1:0] coord_v_i,
  input  logic                      coord_invalid_i,
  output logic                      q_push_o,
  output cmd_t                      q_data_o,
  input  logic                      q_full_i,
  output fe_status_t                status_o
);

  localparam int unsigned PX_W   = COORD_FRAC_BITS + DIM_W;
  localparam int unsigned PY_W   = COORD_FRAC_BITS + 1 + DIM_W;
  localparam int unsigned AREA_W = 2 * DIM_W;

  logic [COORD_FRAC_BITS-1:0] frac_u, frac_v;
  logic [COORD_FRAC_BITS:0]   flip_v;
  logic [PX_W-1:0]            prod_x;
  logic [PY_W-1:0]            prod_y;
  logic [AREA_W-1:0]          area;
  logic                       oversize, dflt, accept;
  logic                       f1_ready, f2_ready;

  logic                 f1_valid_q;
  logic                 f1_is_load_q, f1_dflt_q;
  logic [LOAD_AW-1:0]   f1_addr_q;
  logic [TEXEL_W-1:0]   f1_texel_q;
  logic [DIM_W-1:0]     f1_col_q;
  logic [DIM_W:0]       f1_row_q;

  logic [DIM_W-1:0]     col_lim, col_sel;
  logic [DIM_W:0]       row_lim, row_sel;
  cmd_t                 f2_d, f2_q;
  logic                 f2_valid_q;

  // repeat wrap: keep the fraction bits, flip v
  assign frac_u = coord_u_i[COORD_FRAC_BITS-1:0];
  assign frac_v = coord_v_i[COORD_FRAC_BITS-1:0];
  assign flip_v = {1'b1, {COORD_FRAC_BITS{1'b0}}} - {1'b0, frac_v};

  assign prod_x = PX_W'(frac_u) * PX_W'(cfg_i.width);
  assign prod_y = PY_W'(flip_v) * PY_W'(cfg_i.height);
  assign area   = AREA_W'(cfg_i.width) * AREA_W'(cfg_i.height);

  assign oversize = area > AREA_W'(MAX_TEXELS);
  assign dflt     = (cfg_i.width == '0) || (cfg_i.height == '0) || coord_invalid_i || oversize;

  assign f2_ready = !f2_valid_q || !q_full_i;
  assign f1_ready = !f1_valid_q || f2_ready;
  assign accept   = push && f1_ready;
  assign full     = !f1_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_valid_q <= 1'b0;
    end else if (f1_ready) begin
      f1_valid_q <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f1_is_load_q <= !kind_i;
      f1_dflt_q    <= dflt;
      f1_addr_q    <= load_address_i;
      f1_texel_q   <= load_texel_i;
      f1_col_q     <= prod_x[PX_W-1:COORD_FRAC_BITS];
      f1_row_q     <= prod_y[PY_W-1:COORD_FRAC_BITS];
    end
  end

  // clamp to last column and row
  always_comb begin
    col_lim = cfg_i.width - DIM_W'(1);
    row_lim = {1'b0, cfg_i.height - DIM_W'(1)};
    col_sel = (f1_col_q > col_lim) ? col_lim : f1_col_q;
    row_sel = (f1_row_q > row_lim) ? row_lim : f1_row_q;
    f2_d.is_load   = f1_is_load_q;
    f2_d.dflt      = f1_dflt_q;
    f2_d.load_addr = f1_addr_q;
    f2_d.texel     = f1_texel_q;
    f2_d.col       = col_sel[POS_W-1:0];
    f2_d.row       = row_sel[POS_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f2_valid_q <= 1'b0;
    end else if (f2_ready) begin
      f2_valid_q <= f1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (f2_ready && f1_valid_q) begin
      f2_q <= f2_d;
    end
  end

  assign q_push_o = f2_valid_q && !q_full_i;
  assign q_data_o = f2_q;

  assign status_o.f1_valid = f1_valid_q;
  assign status_o.f2_valid = f2_valid_q;

endmodule

`default_nettype wire

/* rtl/nts_queue.sv */
// nts_queue: short request queue decoupling the front from the back
// depends on nts_pkg
`default_nettype none

module nts_queue import nts_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t data_o,
  output logic empty_o
);

  cmd_t              slot_q [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [Q_AW:0]     count_q;
  logic              do_push, do_pop;

  assign full_o  = count_q == (Q_AW + 1)'(Q_DEPTH);
  assign empty_o = count_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + Q_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + Q_AW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + (Q_AW + 1)'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - (Q_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* rtl/nts_back.sv */
// nts_back: address generation, texel memory access and result buffer
// depends on nts_pkg; consumes requests from nts_queue
`default_nettype none

module nts_back import nts_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_empty_i,
  input  cmd_t               q_data_i,
  output logic               q_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [TEXEL_W-1:0] sampled_texel_o,
  output logic               used_default_o,
  output bk_status_t         status_o
);

  logic [IDX_W-1:0]   lin_idx, smp_idx, ld_idx;
  logic               a_ready, a_go, take;
  logic               credit_ok;
  logic [OB_CW:0]     in_flight;

  logic               a_valid_q, a_is_load_q, a_wr_q, a_dflt_q;
  logic [TEX_AW-1:0]  a_addr_q;
  logic [TEXEL_W-1:0] a_texel_q;

  logic [TEXEL_W-1:0] texel_mem [MAX_TEXELS];
  logic [TEXEL_W-1:0] rd_data_q;
  logic               mem_valid_q, mem_dflt_q;
  logic               mem_we, mem_re;

  logic [TEXEL_W-1:0] ob_texel_q [OB_DEPTH];
  logic               ob_dflt_q  [OB_DEPTH];
  logic [OB_AW-1:0]   ob_wr_q, ob_rd_q;
  logic [OB_CW-1:0]   ob_count_q;
  logic               ob_push, ob_pop;

  // texel index y*width+x, clamped into the store
  assign lin_idx = IDX_W'(q_data_i.row) * IDX_W'(cfg_i.width) + IDX_W'(q_data_i.col);
  assign smp_idx = (lin_idx >= IDX_W'(MAX_TEXELS)) ? IDX_W'(MAX_TEXELS - 1) : lin_idx;
  assign ld_idx  = IDX_W'(q_data_i.load_addr);

  // result slots already promised: buffered plus the read in flight
  assign in_flight = {1'b0, ob_count_q} + (OB_CW + 1)'(mem_valid_q);
  assign credit_ok = in_flight < (OB_CW + 1)'(OB_DEPTH);

  assign a_go    = a_valid_q && (a_is_load_q || credit_ok);
  assign a_ready = !a_valid_q || a_go;
  assign take    = !q_empty_i && a_ready;
  assign q_pop_o = take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= !q_empty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_is_load_q <= q_data_i.is_load;
      a_wr_q      <= q_data_i.is_load && (ld_idx < IDX_W'(MAX_TEXELS));
      a_dflt_q    <= q_data_i.dflt;
      a_addr_q    <= q_data_i.is_load ? ld_idx[TEX_AW-1:0] : smp_idx[TEX_AW-1:0];
      a_texel_q   <= q_data_i.texel;
    end
  end

  // single port texel memory, one access per cycle in request order unless a sample waits for result buffer room
  assign mem_we = a_go && a_wr_q;
  assign mem_re = a_go && !a_is_load_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      texel_mem[a_addr_q] <= a_texel_q;
    end
    if (mem_re) begin
      rd_data_q  <= texel_mem[a_addr_q];
      mem_dflt_q <= a_dflt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_valid_q <= 1'b0;
    end else begin
      mem_valid_q <= mem_re;
    end
  end

  // result buffer
  assign ob_push = mem_valid_q;
  assign ob_pop  = pop && !empty;
  assign empty   = ob_count_q == '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_wr_q    <= '0;
      ob_rd_q    <= '0;
      ob_count_q <= '0;
    end else begin
      if (ob_push) begin
        ob_wr_q <= ob_wr_q + OB_AW'(1);
      end
      if (ob_pop) begin
        ob_rd_q <= ob_rd_q + OB_AW'(1);
      end
      if (ob_push && !ob_pop) begin
        ob_count_q <= ob_count_q + OB_CW'(1);
      end else if (ob_pop && !ob_push) begin
        ob_count_q <= ob_count_q - OB_CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ob_push) begin
      ob_texel_q[ob_wr_q] <= mem_dflt_q ? OPAQUE_WHITE : rd_data_q;
      ob_dflt_q[ob_wr_q]  <= mem_dflt_q;
    end
  end

  assign sampled_texel_o = ob_texel_q[ob_rd_q];
  assign used_default_o  = ob_dflt_q[ob_rd_q];

  assign status_o.a_valid   = a_valid_q;
  assign status_o.mem_valid = mem_valid_q;
  assign status_o.ob_count  = ob_count_q;

endmodule

`default_nettype wire

/* rtl/nearest_texture_sampler_top.sv */
// nearest_texture_sampler_top: texel store with nearest-neighbor repeat-wrap sampler
// depends on nts_pkg, nts_front, nts_queue, nts_back
//
//   channel   direction  handshake                 payload
//   request   in         push / full               kind, load_address, load_texel,
//                                                  coord_u, coord_v, coord_invalid
//   result    out        empty / pop               sampled_texel, used_default
//   config    in         cfg_we_i (no wait)        cfg_index_i, cfg_data_i
//
// one request per cycle sustained when the result side does not stall, loads and samples
// mixed; a sample request passes, in order, the first front stage, loaded at the accepting
// edge, the second front stage, the queue, the address stage, the memory read and the
// result buffer
// reset clears the pipeline, the queues and both dimension registers; the texel
// memory holds no reset value and needs no clearing pass
// a stalled result side fills the result buffer, then the back, the queue and the front
`default_nettype none

module nearest_texture_sampler_top import nts_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request side
  input  logic                        push,
  output logic                        full,
  input  logic                        kind_i,
  input  logic        [LOAD_AW-1:0]   load_address_i,
  input  logic        [TEXEL_W-1:0]   load_texel_i,
  input  logic signed [COORD_W-1:0]   coord_u_i,
  input  logic signed [COORD_W-1:0]   coord_v_i,
  input  logic                        coord_invalid_i,
  // result side
  output logic                        empty,
  input  logic                        pop,
  output logic        [TEXEL_W-1:0]   sampled_texel_o,
  output logic                        used_default_o,
  // configuration
  input  logic                        cfg_we_i,
  input  logic        [CFG_IDX_W-1:0] cfg_index_i,
  input  logic        [DIM_W-1:0]     cfg_data_i
);

  cfg_t       cfg_q;
  logic       q_push, q_full, q_pop, q_empty;
  cmd_t       q_wdata, q_rdata;
  fe_status_t fe_status;
  bk_status_t bk_status;

  // dimension registers; the user must write them only while the sampler is idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TEX_WIDTH:  cfg_q.width  <= cfg_data_i;
        REG_TEX_HEIGHT: cfg_q.height <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: accept, flag default cases, wrap, scale and clamp coordinates
  nts_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .push            (push),
    .full            (full),
    .kind_i          (kind_i),
    .load_address_i  (load_address_i),
    .load_texel_i    (load_texel_i),
    .coord_u_i       (coord_u_i),
    .coord_v_i       (coord_v_i),
    .coord_invalid_i (coord_invalid_i),
    .q_push_o        (q_push),
    .q_data_o        (q_wdata),
    .q_full_i        (q_full),
    .status_o        (fe_status)
  );

  // request queue between front and back
  nts_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  // back: texel index, memory access, result buffer
  nts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .q_empty_i       (q_empty),
    .q_data_i        (q_rdata),
    .q_pop_o         (q_pop),
    .empty           (empty),
    .pop             (pop),
    .sampled_texel_o (sampled_texel_o),
    .used_default_o  (used_default_o),
    .status_o        (bk_status)
  );

`ifndef SYNTH
  // backpressure on the request side only comes from a full queue
  a_full_from_queue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> (fe_status.f1_valid && fe_status.f2_valid && q_full))
    else $error("request side full while queue has room");

  // a memory read only follows an issued address stage request
  a_read_after_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_status.mem_valid |-> $past(bk_status.a_valid))
    else $error("texel read without an address stage request");

  // reads in flight never overrun the result buffer
  a_result_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, bk_status.ob_count} + (OB_CW + 1)'(bk_status.mem_valid))
      <= (OB_CW + 1)'(OB_DEPTH))
    else $error("result buffer overrun");
`endif

endmodule

`default_nettype wire
